// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PDLL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define PDLL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pdll_pkg.sv =====
package pdll_pkg;

  localparam int NodeCountDef = 128;
  localparam int ListCountDef = 16;

  // Request codes.
  localparam logic [2:0] REQ_OPEN    = 3'd0;
  localparam logic [2:0] REQ_AFTER   = 3'd1;
  localparam logic [2:0] REQ_BEFORE  = 3'd2;
  localparam logic [2:0] REQ_APPEND  = 3'd3;
  localparam logic [2:0] REQ_PREPEND = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_NODE  = 2'd1;
  localparam logic [1:0] ST_NO_LIST  = 2'd2;
  localparam logic [1:0] ST_NOT_OPEN = 2'd3;

  // Markers for "none" in the result fields.
  localparam logic [4:0] LIST_NONE = 5'd16;
  localparam logic [7:0] NODE_NONE = 8'd128;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  list_id;
    logic [31:0] item_data;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] result_list;
    logic [7:0] node_used;
    logic [7:0] list_length;
  } res_item_t;

endpackage

// ===== rtl/pooled_doubly_linked_list_engine.sv =====
// An open request, an unknown code or a request to a list that is not open goes from
// acceptance straight to the output step. Any other request first reads its list header;
// one that finds no free node then goes to the output step, and an insert writes its links,
// after a read of the cursor's neighbour when the new node goes in the middle of a list.
// One request at a time, set by the single ports of the list table and node link memories.
// Reset: asynchronous and active low; both free chains are ready at once, with no sweep.
module pooled_doubly_linked_list_engine
  import pdll_pkg::*;
#(
  parameter int NODE_COUNT = NodeCountDef,
  parameter int LIST_COUNT = ListCountDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  req_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output res_item_t out_item_o
);

`include "assert_macros.svh"

  // Node indices carry one extra code for null; list ids likewise.
  localparam int NW  = $clog2(NODE_COUNT + 1);
  localparam int AW  = $clog2(NODE_COUNT);
  localparam int LW  = $clog2(LIST_COUNT + 1);
  localparam int LAW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam logic [NW-1:0] NodeNil = NW'(NODE_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LRD,
    S_NRD,
    S_WR,
    S_OUT
  } state_e;

  state_e    state_q;
  req_item_t req_q;
  res_item_t res_q;
  res_item_t out_q;
  logic      out_valid_q;

  // Nodes and list headers are never returned, so each free chain is simply
  // popped in index order and its head is a counter.
  logic [NW-1:0] fnh_q;
  logic [LW-1:0] flh_q;

  logic [NW-1:0] head_q, tail_q, cur_q, cnt_q, nxt_q, prv_q;

  // List table: head, tail, cursor and count packed in one word.
  logic            lt_en, lt_we;
  logic [LAW-1:0]  lt_addr;
  logic [4*NW-1:0] lt_wdata, lt_rdata;
  logic [NW-1:0]   lt_head, lt_tail, lt_cur, lt_cnt;

  logic          nx_en, nx_we, pv_en, pv_we, py_en;
  logic [AW-1:0] nx_addr, pv_addr, nn_addr;
  logic [NW-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;
  logic [31:0]   py_rdata;

  logic in_acc;
  logic id_open, list_free, node_full;
  logic is_empty, is_app, is_pre, is_mid;
  logic [NW-1:0] link;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign id_open   = ({28'd0, in_item_i.list_id} < 32'(LIST_COUNT)) &&
                     (32'(in_item_i.list_id) < 32'(flh_q));
  assign list_free = (32'(flh_q) < 32'(LIST_COUNT));
  assign node_full = (32'(fnh_q) >= 32'(NODE_COUNT));
  assign nn_addr   = AW'(fnh_q);

  assign lt_head = lt_rdata[4*NW-1:3*NW];
  assign lt_tail = lt_rdata[3*NW-1:2*NW];
  assign lt_cur  = lt_rdata[2*NW-1:NW];
  assign lt_cnt  = lt_rdata[NW-1:0];

  // Placement of the new node, decided once the list header is back.
  assign is_empty = (lt_cnt == '0);
  assign is_app   = !is_empty && ((req_q.req_type == REQ_APPEND) ||
                    ((req_q.req_type == REQ_AFTER) && (lt_cur == lt_tail)));
  assign is_pre   = !is_empty && !is_app && ((req_q.req_type == REQ_PREPEND) ||
                    ((req_q.req_type == REQ_BEFORE) && (lt_cur == lt_head)));
  assign is_mid   = !is_empty && !is_app && !is_pre;

  // The neighbour read from the link memories in the middle cases.
  assign link = (req_q.req_type == REQ_AFTER) ? nx_rdata : pv_rdata;

  always_comb begin
    lt_en    = 1'b0;
    lt_we    = 1'b0;
    lt_addr  = LAW'(req_q.list_id);
    lt_wdata = '0;
    nx_en    = 1'b0;
    nx_we    = 1'b0;
    nx_addr  = nn_addr;
    nx_wdata = NW'(fnh_q);
    pv_en    = 1'b0;
    pv_we    = 1'b0;
    pv_addr  = nn_addr;
    pv_wdata = NW'(fnh_q);
    py_en    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item_i.req_type == REQ_OPEN) begin
            if (list_free) begin
              lt_en    = 1'b1;
              lt_we    = 1'b1;
              lt_addr  = LAW'(flh_q);
              lt_wdata = {NodeNil, NodeNil, NodeNil, NW'(0)};
            end
          end else if ((in_item_i.req_type <= REQ_PREPEND) && id_open) begin
            lt_en   = 1'b1;
            lt_addr = LAW'(in_item_i.list_id);
          end
        end
      end
      S_LRD: begin
        if (!node_full) begin
          lt_en    = 1'b1;
          lt_we    = 1'b1;
          lt_wdata = {(is_empty || is_pre) ? fnh_q : lt_head,
                      (is_empty || is_app) ? fnh_q : lt_tail,
                      fnh_q, lt_cnt + NW'(1)};
          if (is_app) begin
            nx_en   = 1'b1;
            nx_we   = 1'b1;
            nx_addr = AW'(lt_tail);
          end
          if (is_pre) begin
            pv_en   = 1'b1;
            pv_we   = 1'b1;
            pv_addr = AW'(lt_head);
          end
          if (is_mid) begin
            if (req_q.req_type == REQ_AFTER) begin
              nx_en   = 1'b1;
              nx_addr = AW'(lt_cur);
            end else begin
              pv_en   = 1'b1;
              pv_addr = AW'(lt_cur);
            end
          end
        end
      end
      S_NRD: begin
        // Splice the new node between the cursor and its neighbour.
        if (req_q.req_type == REQ_AFTER) begin
          nx_en   = 1'b1;
          nx_we   = 1'b1;
          nx_addr = AW'(cur_q);
          pv_en   = (32'(link) < 32'(NODE_COUNT));
          pv_we   = 1'b1;
          pv_addr = AW'(link);
        end else begin
          pv_en   = 1'b1;
          pv_we   = 1'b1;
          pv_addr = AW'(cur_q);
          nx_en   = (32'(link) < 32'(NODE_COUNT));
          nx_we   = 1'b1;
          nx_addr = AW'(link);
        end
      end
      S_WR: begin
        nx_en    = 1'b1;
        nx_we    = 1'b1;
        nx_wdata = nxt_q;
        pv_en    = 1'b1;
        pv_we    = 1'b1;
        pv_wdata = prv_q;
        py_en    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      fnh_q       <= '0;
      flh_q       <= '0;
    end else begin
      // The output step below sets the valid itself when it loads a new item.
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q <= in_item_i;
            state_q <= S_OUT;
            if (in_item_i.req_type == REQ_OPEN) begin
              if (list_free) begin
                res_q <= '{ST_OK, 5'(flh_q), NODE_NONE, 8'd0};
                flh_q <= flh_q + LW'(1);
              end else begin
                res_q <= '{ST_NO_LIST, LIST_NONE, NODE_NONE, 8'd0};
              end
            end else if (in_item_i.req_type > REQ_PREPEND) begin
              res_q <= '{ST_OK, LIST_NONE, NODE_NONE, 8'd0};
            end else if (!id_open) begin
              res_q <= '{ST_NOT_OPEN, 5'(in_item_i.list_id), NODE_NONE, 8'd0};
            end else begin
              state_q <= S_LRD;
            end
          end
        end
        S_LRD: begin
          if (node_full) begin
            res_q   <= '{ST_NO_NODE, 5'(req_q.list_id), NODE_NONE, 8'(lt_cnt)};
            state_q <= S_OUT;
          end else begin
            head_q <= lt_head;
            tail_q <= lt_tail;
            cur_q  <= lt_cur;
            cnt_q  <= lt_cnt + NW'(1);
            nxt_q  <= is_pre ? lt_head : NodeNil;
            prv_q  <= is_app ? lt_tail : NodeNil;
            state_q <= is_mid ? S_NRD : S_WR;
          end
        end
        S_NRD: begin
          if (req_q.req_type == REQ_AFTER) begin
            nxt_q <= link;
            prv_q <= cur_q;
          end else begin
            nxt_q <= cur_q;
            prv_q <= link;
          end
          state_q <= S_WR;
        end
        S_WR: begin
          res_q   <= '{ST_OK, 5'(req_q.list_id), 8'(fnh_q), 8'(cnt_q)};
          fnh_q   <= fnh_q + NW'(1);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  pdll_ram #(.Width(4 * NW), .Depth(LIST_COUNT), .AddrW(LAW)) u_list_tab (
    .clk_i  (clk_i),
    .en_i   (lt_en),
    .we_i   (lt_we),
    .addr_i (lt_addr),
    .wdata_i(lt_wdata),
    .rdata_o(lt_rdata)
  );

  pdll_ram #(.Width(NW), .Depth(NODE_COUNT), .AddrW(AW)) u_node_next (
    .clk_i  (clk_i),
    .en_i   (nx_en),
    .we_i   (nx_we),
    .addr_i (nx_addr),
    .wdata_i(nx_wdata),
    .rdata_o(nx_rdata)
  );

  pdll_ram #(.Width(NW), .Depth(NODE_COUNT), .AddrW(AW)) u_node_prev (
    .clk_i  (clk_i),
    .en_i   (pv_en),
    .we_i   (pv_we),
    .addr_i (pv_addr),
    .wdata_i(pv_wdata),
    .rdata_o(pv_rdata)
  );

  pdll_ram #(.Width(32), .Depth(NODE_COUNT), .AddrW(AW)) u_node_pay (
    .clk_i  (clk_i),
    .en_i   (py_en),
    .we_i   (1'b1),
    .addr_i (nn_addr),
    .wdata_i(req_q.item_data),
    .rdata_o(py_rdata)
  );

  // The payload is stored for the user of the pool and never read back here.
  logic unused_pay;
  assign unused_pay = ^py_rdata ^ ^head_q ^ ^tail_q;

  `PDLL_ASSERT(a_fnh_range, clk_i, rst_ni, (32'(fnh_q) <= 32'(NODE_COUNT)), "node head past pool")
  `PDLL_ASSERT(a_wr_has_node, clk_i, rst_ni, ((state_q == S_WR) |-> !node_full), "node write with empty pool")
  `PDLL_ASSERT(a_out_from_seq, clk_i, rst_ni, ($rose(out_valid_q) |-> ($past(state_q) == S_OUT)), "item shown outside the output step")

endmodule

// ===== rtl/pdll_ram.sv =====
// Single-port synchronous memory with a registered read.
module pdll_ram #(
  parameter int Width = 8,
  parameter int Depth = 128,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
